>>> design/btn_db_pkg.sv
// Shared types and constants for the button debouncer with short and long press detection.
// Used by the lane, the merge stage and the top level; depends on nothing.
package btn_db_pkg;

  localparam int PinW   = 8;
  localparam int CfgTW  = 16;
  localparam int MaxLanes = 8;
  localparam int ApbAw  = 4;
  localparam int ApbDw  = 32;

  localparam logic [CfgTW-1:0] DebounceRst  = 16'd50;
  localparam logic [CfgTW-1:0] LongPressRst = 16'd1000;
  localparam logic [PinW-1:0]  ActLowRst    = 8'hFF;
  localparam logic [PinW-1:0]  EnableRst    = 8'h00;

  typedef enum logic [1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_ACTIVE_LOW = 2'd2,
    REG_ENABLE     = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CfgTW-1:0] debounce_ms;
    logic [CfgTW-1:0] long_press_ms;
  } timing_cfg_t;

  typedef struct packed {
    logic short_ev;
    logic long_ev;
  } lane_evt_t;

endpackage

>>> design/btn_db_lane.sv
// One button lane: debounce wait, stable state and press timer for a single pin.
// Depends on btn_db_pkg for the timing configuration and event types.
module btn_db_lane #(
  parameter int TIMER_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic                     changed_i,
  input  logic                     level_i,
  input  logic                     active_low_i,
  input  btn_db_pkg::timing_cfg_t  cfg_i,
  output btn_db_pkg::lane_evt_t    evt_o
);
  import btn_db_pkg::*;

  localparam int CmpW = (TIMER_BITS > CfgTW) ? TIMER_BITS : CfgTW;

  logic [TIMER_BITS-1:0] settle_q, settle_d, hold_q, hold_d;
  logic pend_q, pend_d, stable_q, stable_d, held_q, held_d, lrep_q, lrep_d;
  logic settle_done, pressed, long_hit;

  always_comb begin
    settle_d = settle_q;
    hold_d   = hold_q;
    pend_d   = pend_q;
    stable_d = stable_q;
    held_d   = held_q;
    lrep_d   = lrep_q;
    evt_o    = '0;

    // advance the press timer, saturating
    if (held_q && (hold_q != '1)) begin
      hold_d = hold_q + 1'b1;
    end

    // restart or advance the debounce wait
    if (changed_i) begin
      pend_d   = 1'b1;
      settle_d = '0;
    end else if (pend_q && (settle_q != '1)) begin
      settle_d = settle_q + 1'b1;
    end

    settle_done = pend_d && (CmpW'(settle_d) >= CmpW'(cfg_i.debounce_ms));
    pressed     = level_i ^ active_low_i;

    if (settle_done) begin
      pend_d = 1'b0;
      if (pressed != stable_q) begin
        stable_d = pressed;
        if (pressed) begin
          held_d = 1'b1;
          hold_d = '0;
          lrep_d = 1'b0;
        end else if (held_q) begin
          held_d         = 1'b0;
          evt_o.short_ev = !lrep_q;
        end
      end
    end

    long_hit = held_d && !lrep_d && (CmpW'(hold_d) >= CmpW'(cfg_i.long_press_ms));
    if (long_hit) begin
      lrep_d        = 1'b1;
      evt_o.long_ev = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= '0;
      hold_q   <= '0;
      pend_q   <= 1'b0;
      stable_q <= 1'b0;
      held_q   <= 1'b0;
      lrep_q   <= 1'b0;
    end else if (step_i) begin
      settle_q <= settle_d;
      hold_q   <= hold_d;
      pend_q   <= pend_d;
      stable_q <= stable_d;
      held_q   <= held_d;
      lrep_q   <= lrep_d;
    end
  end

endmodule

>>> design/btn_db_merge.sv
// Merge stage: packs the lane events into the two result masks and holds the output beat.
// Depends on btn_db_pkg for the lane event type and the mask width.
module btn_db_merge #(
  parameter int NUM_LANES = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  btn_db_pkg::lane_evt_t          evt_i [NUM_LANES],
  input  logic                           out_stall_i,
  output logic                           busy_o,
  output logic                           out_valid_o,
  output logic [btn_db_pkg::PinW-1:0]    short_press_mask_o,
  output logic [btn_db_pkg::PinW-1:0]    long_press_mask_o
);
  import btn_db_pkg::*;

  logic            valid_q, valid_d;
  logic [PinW-1:0] short_q, short_d, long_q, long_d;

  always_comb begin
    short_d = '0;
    long_d  = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      short_d[i] = evt_i[i].short_ev;
      long_d[i]  = evt_i[i].long_ev;
    end
    valid_d = load_i || (valid_q && out_stall_i);
  end

  // hold the beat while the receiver stalls
  assign busy_o = valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      short_q <= short_d;
      long_q  <= long_d;
    end
  end

  assign out_valid_o        = valid_q;
  assign short_press_mask_o = short_q;
  assign long_press_mask_o  = long_q;

endmodule

>>> design/button_debounce_short_long_press.sv
// Top level of the button debouncer with short and long press detection.
// Depends on btn_db_pkg, btn_db_lane and btn_db_merge.
//
// Usage: feed one beat per millisecond tick on the input channel (in_valid_i, in_stall_o,
// pin_levels_i); bit i of pin_levels_i is the raw level of button i. Every accepted beat
// yields exactly one result beat on the output channel (out_valid_o, out_stall_i) carrying
// short_press_mask_o and long_press_mask_o for that tick.
// The output is valid in the cycle after the input beat is accepted. Throughput: one beat per
// cycle while the output is not stalled; each button has its own lane that does its whole tick
// update for each accepted beat, and the merge stage registers the masks.
// Stall: the output register holds its beat while out_stall_i is high; in_stall_o is then
// raised in the same cycle, so no beat is taken until the held result leaves.
// Reset: all lane state, last pin levels and the output valid clear; the registers return
// to debounce 50, long press 1000, all buttons active low and all buttons disabled.
// Configuration: APB writes at byte address 4*i, to be done only while the block is idle.
// A disabled button keeps its lane frozen and reports nothing.
module button_debounce_short_long_press #(
  parameter int NUM_BUTTONS = 8,
  parameter int TIMER_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [btn_db_pkg::PinW-1:0]         pin_levels_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [btn_db_pkg::PinW-1:0]         short_press_mask_o,
  output logic [btn_db_pkg::PinW-1:0]         long_press_mask_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [btn_db_pkg::ApbAw-1:0]        paddr,
  input  logic [btn_db_pkg::ApbDw-1:0]        pwdata,
  output logic [btn_db_pkg::ApbDw-1:0]        prdata,
  output logic                                pready
);
  import btn_db_pkg::*;

  // lanes beyond the pin vector have no input and are not built
  localparam int Lanes = (NUM_BUTTONS < MaxLanes) ? NUM_BUTTONS : MaxLanes;

  timing_cfg_t     cfg_q;
  logic [PinW-1:0] act_low_q, enable_q;
  logic [PinW-1:0] last_q, changed;
  logic            accept, cfg_wr, merge_busy;
  reg_idx_e        reg_sel;
  lane_evt_t       lane_evt [Lanes];

  // ---------------------------------------------------------------- config port
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms   <= DebounceRst;
      cfg_q.long_press_ms <= LongPressRst;
      act_low_q           <= ActLowRst;
      enable_q            <= EnableRst;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_DEBOUNCE:   cfg_q.debounce_ms   <= pwdata[CfgTW-1:0];
        REG_LONG_PRESS: cfg_q.long_press_ms <= pwdata[CfgTW-1:0];
        REG_ACTIVE_LOW: act_low_q           <= pwdata[PinW-1:0];
        REG_ENABLE:     enable_q            <= pwdata[PinW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DEBOUNCE:   prdata = ApbDw'(cfg_q.debounce_ms);
      REG_LONG_PRESS: prdata = ApbDw'(cfg_q.long_press_ms);
      REG_ACTIVE_LOW: prdata = ApbDw'(act_low_q);
      REG_ENABLE:     prdata = ApbDw'(enable_q);
    endcase
  end

  // ---------------------------------------------------------------- input side
  // take a new tick whenever the output register can take its result
  assign in_stall_o = merge_busy;
  assign accept     = in_valid_i && !merge_busy;
  assign changed    = pin_levels_i ^ last_q;

  // last levels follow every pin, enabled or not
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (accept) begin
      last_q <= pin_levels_i;
    end
  end

  // ---------------------------------------------------------------- lanes
  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    btn_db_lane #(
      .TIMER_BITS (TIMER_BITS)
    ) u_lane (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .step_i       (accept && enable_q[g]),
      .changed_i    (changed[g]),
      .level_i      (pin_levels_i[g]),
      .active_low_i (act_low_q[g]),
      .cfg_i        (cfg_q),
      .evt_o        (lane_evt[g])
    );
  end

  // ---------------------------------------------------------------- merge and output
  // a disabled lane does not step, so its events are masked here
  lane_evt_t lane_evt_m [Lanes];
  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      lane_evt_m[i].short_ev = lane_evt[i].short_ev && enable_q[i];
      lane_evt_m[i].long_ev  = lane_evt[i].long_ev && enable_q[i];
    end
  end

  btn_db_merge #(
    .NUM_LANES (Lanes)
  ) u_merge (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .load_i             (accept),
    .evt_i              (lane_evt_m),
    .out_stall_i        (out_stall_i),
    .busy_o             (merge_busy),
    .out_valid_o        (out_valid_o),
    .short_press_mask_o (short_press_mask_o),
    .long_press_mask_o  (long_press_mask_o)
  );

  // ---------------------------------------------------------------- assertions
  a_valid_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o))
    else $error("output beat appeared without an accepted tick");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input accepted while a stalled result is held");

  a_no_short_and_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((short_press_mask_o & long_press_mask_o) == '0))
    else $error("button reported short and long press in one tick");

  a_only_enabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (((short_press_mask_o | long_press_mask_o) & ~enable_q) == '0))
    else $error("disabled button reported an event");

endmodule
